// ----- rtl/keyboard_report_change_events_macros.svh -----
// Assertion macros for the keyboard report change event block.
// Included by RTL files that carry concurrent checks; SYNTH builds drop them.
`ifndef KEYBOARD_REPORT_CHANGE_EVENTS_MACROS_SVH
`define KEYBOARD_REPORT_CHANGE_EVENTS_MACROS_SVH
`ifndef SYNTH
`define KRCE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("krce check failed");
`define KRCE_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("krce check failed");
`else
`define KRCE_ASSERT(lbl, clk, rstn, prop)
`define KRCE_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/krce_pkg.sv -----
// Shared types and constants for the keyboard report change event block.
// No dependencies.
`timescale 1ns / 1ps

package krce_pkg;

    localparam int MAX_EVENTS = 32;
    localparam int CNT_W      = 6;
    localparam logic [6:0] BASE_NOTE = 7'h30;

    typedef enum logic [3:0] {
        EV_PRESS       = 4'd0,
        EV_RELEASE     = 4'd1,
        EV_SUSTAIN     = 4'd2,
        EV_STOMP       = 4'd3,
        EV_MOD         = 4'd4,
        EV_EXPRESSION  = 4'd5,
        EV_ACCESSORIES = 4'd6,
        EV_LOW_HAND    = 4'd7,
        EV_HIGH_HAND   = 4'd8,
        EV_ACCEL       = 4'd9
    } t_kind;

    typedef struct packed {
        logic [1:0]  pad;
        logic [63:0] report_head;
        logic        sustain_pedal;
        logic        stomp_pedal;
        logic [7:0]  axis_x;
        logic [7:0]  axis_y;
        logic [7:0]  axis_z;
        logic [7:0]  expression_pedal;
        logic [7:0]  accessories;
        logic [7:0]  low_hand;
        logic [3:0]  high_hand_bits;
    } t_report;

    typedef struct packed {
        t_kind       event_kind;
        logic [1:0]  event_pad;
        logic [6:0]  note;
        logic [7:0]  value;
        logic [7:0]  value_y;
        logic [7:0]  value_z;
        logic        last;
    } t_event;

    // stored per-pad state except the key bits
    typedef struct packed {
        logic        sustain;
        logic        stomp;
        logic [7:0]  mod;
        logic [7:0]  expr;
        logic [7:0]  acc;
        logic [7:0]  low;
        logic [3:0]  high;
        logic [23:0] tilt;
    } t_pad_state;

    typedef struct packed {
        logic        is_key;
        t_kind       kind;
        logic        key_now;
        logic        key_was;
        logic [6:0]  note;
        logic [6:0]  vel;
    } t_step;

    typedef struct packed {
        logic        differ;
        t_event      ev;
        t_pad_state  state;
    } t_result;

endpackage

// ----- rtl/krce_ifs.sv -----
// Channel interfaces: report input, event output and config write.
// No dependencies.
`timescale 1ns / 1ps

interface krce_report_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pad;
    logic [63:0] report_head;
    logic        sustain_pedal;
    logic        stomp_pedal;
    logic [7:0]  axis_x;
    logic [7:0]  axis_y;
    logic [7:0]  axis_z;
    logic [7:0]  expression_pedal;
    logic [7:0]  accessories;
    logic [7:0]  low_hand;
    logic [3:0]  high_hand_bits;

    modport source (
        output valid, pad, report_head, sustain_pedal, stomp_pedal, axis_x, axis_y,
               axis_z, expression_pedal, accessories, low_hand, high_hand_bits,
        input  ready
    );
    modport sink (
        input  valid, pad, report_head, sustain_pedal, stomp_pedal, axis_x, axis_y,
               axis_z, expression_pedal, accessories, low_hand, high_hand_bits,
        output ready
    );
endinterface

interface krce_event_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_kind;
    logic [1:0]  event_pad;
    logic [6:0]  note;
    logic [7:0]  value;
    logic [7:0]  value_y;
    logic [7:0]  value_z;
    logic        last;

    modport source (
        output valid, event_kind, event_pad, note, value, value_y, value_z, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_pad, note, value, value_y, value_z, last,
        output ready
    );
endinterface

interface krce_cfg_if;
    logic valid;
    logic ready;
    logic use_midi_port;

    modport source (output valid, use_midi_port, input ready);
    modport sink (input valid, use_midi_port, output ready);
endinterface

// ----- rtl/krce_unit.sv -----
// Shared compare unit: checks one key or one field against the stored pad state,
// builds the candidate event and the updated state. Uses krce_pkg.
`timescale 1ns / 1ps

module krce_unit (
    input  krce_pkg::t_report    i_rep,
    input  krce_pkg::t_pad_state i_old,
    input  krce_pkg::t_step      i_step,
    output krce_pkg::t_result    o_res
);

    always_comb begin
        o_res              = '0;
        o_res.state        = i_old;
        o_res.ev.event_pad = i_rep.pad;
        o_res.ev.event_kind = i_step.kind;
        if (i_step.is_key) begin
            o_res.differ        = i_step.key_now != i_step.key_was;
            o_res.ev.event_kind = i_step.key_now ? krce_pkg::EV_PRESS : krce_pkg::EV_RELEASE;
            o_res.ev.note       = i_step.note;
            o_res.ev.value      = i_step.key_now ? {1'b0, i_step.vel} : 8'd0;
        end else begin
            case (i_step.kind)
                krce_pkg::EV_SUSTAIN: begin
                    o_res.differ        = i_rep.sustain_pedal != i_old.sustain;
                    o_res.state.sustain = i_rep.sustain_pedal;
                    o_res.ev.value      = {7'd0, i_rep.sustain_pedal};
                end
                krce_pkg::EV_STOMP: begin
                    o_res.differ      = i_rep.stomp_pedal != i_old.stomp;
                    o_res.state.stomp = i_rep.stomp_pedal;
                    o_res.ev.value    = {7'd0, i_rep.stomp_pedal};
                end
                krce_pkg::EV_MOD: begin
                    o_res.differ    = i_rep.axis_x != i_old.mod;
                    o_res.state.mod = i_rep.axis_x;
                    o_res.ev.value  = i_rep.axis_x;
                end
                krce_pkg::EV_EXPRESSION: begin
                    o_res.differ     = i_rep.expression_pedal != i_old.expr;
                    o_res.state.expr = i_rep.expression_pedal;
                    o_res.ev.value   = i_rep.expression_pedal;
                end
                krce_pkg::EV_ACCESSORIES: begin
                    o_res.differ    = i_rep.accessories != i_old.acc;
                    o_res.state.acc = i_rep.accessories;
                    o_res.ev.value  = i_rep.accessories;
                end
                krce_pkg::EV_LOW_HAND: begin
                    o_res.differ    = i_rep.low_hand != i_old.low;
                    o_res.state.low = i_rep.low_hand;
                    o_res.ev.value  = i_rep.low_hand;
                end
                krce_pkg::EV_HIGH_HAND: begin
                    o_res.differ     = i_rep.high_hand_bits != i_old.high;
                    o_res.state.high = i_rep.high_hand_bits;
                    o_res.ev.value   = {4'd0, i_rep.high_hand_bits};
                end
                krce_pkg::EV_ACCEL: begin
                    o_res.differ     = {i_rep.axis_x, i_rep.axis_y, i_rep.axis_z} != i_old.tilt;
                    o_res.state.tilt = {i_rep.axis_x, i_rep.axis_y, i_rep.axis_z};
                    o_res.ev.value   = i_rep.axis_x;
                    o_res.ev.value_y = i_rep.axis_y;
                    o_res.ev.value_z = i_rep.axis_z;
                end
                default: begin
                    o_res.differ = 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/keyboard_report_change_events.sv -----
// Top level: per-pad report change detector with a key/field scan sequencer.
// Uses krce_pkg, the krce interfaces, krce_unit and the assertion macro header.
// Each event is held back until the next one is found; the held one leaves at flush
// as the final event of the item (last). A new report is taken only while idle, after
// the previous one has flushed. One key or field per cycle while the event output is not stalled.
// Reset (synchronous, active low) clears all stored pad state and the config bit.
`timescale 1ns / 1ps
`include "keyboard_report_change_events_macros.svh"

module keyboard_report_change_events #(
    parameter int PAD_COUNT      = 4,
    parameter int KEY_COUNT      = 25,
    parameter int VELOCITY_SLOTS = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    krce_report_if.sink        i_in,
    krce_event_if.source       o_ev,
    krce_cfg_if.sink           i_cfg
);

    localparam int PW    = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int KW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int SW_R  = $clog2(KEY_COUNT + 2);
    localparam int SW    = (SW_R < 3) ? 3 : SW_R;
    localparam int CNT_W = krce_pkg::CNT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_KEYS, ST_FIELDS, ST_FLUSH} t_state;

    t_state                 r_state;
    logic                   r_use_midi;
    krce_pkg::t_report      r_rep;
    logic [KW-1:0]          r_key;
    krce_pkg::t_kind        r_fld;
    logic [SW-1:0]          r_slot;
    logic [CNT_W-1:0]       r_count;
    krce_pkg::t_event       r_pend;
    logic                   r_pend_v;
    krce_pkg::t_event       r_out;
    logic                   r_out_v;
    logic [KEY_COUNT-1:0]   r_key_down [PAD_COUNT];
    krce_pkg::t_pad_state   r_pst      [PAD_COUNT];

    logic [PW-1:0]          w_pidx;
    logic [KEY_COUNT-1:0]   w_keys;
    logic [6:0]             w_vel;
    logic                   w_pad_ok;
    krce_pkg::t_step        w_step;
    krce_pkg::t_result      w_res;
    logic                   w_scan;
    logic                   w_emit;
    logic                   w_out_free;
    logic                   w_go;
    logic                   w_push;
    krce_pkg::t_event       w_out_next;

    assign w_pidx   = PW'(r_rep.pad);
    assign w_pad_ok = {2'b00, i_in.pad} < 4'(PAD_COUNT);

    // key k sits in byte k/8, bit 7-k%8, i.e. head bit 63-k
    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            w_keys[k] = r_rep.report_head[63 - k];
        end
    end

    // slot s takes low 7 bits of byte s+2
    always_comb begin
        w_vel = 7'd0;
        for (int s = 1; s <= 5; s++) begin
            if (s <= VELOCITY_SLOTS && r_slot == SW'(s)) begin
                w_vel = r_rep.report_head[62 - 8 * (s + 2) -: 7];
            end
        end
    end

    always_comb begin
        w_step         = '0;
        w_step.is_key  = (r_state == ST_KEYS);
        w_step.kind    = r_fld;
        w_step.key_now = w_keys[r_key];
        w_step.key_was = r_key_down[w_pidx][r_key];
        w_step.note    = krce_pkg::BASE_NOTE + 7'(r_key);
        w_step.vel     = w_vel;
    end

    krce_unit u_unit (
        .i_rep  (r_rep),
        .i_old  (r_pst[w_pidx]),
        .i_step (w_step),
        .o_res  (w_res)
    );

    assign w_scan     = (r_state == ST_KEYS) || (r_state == ST_FIELDS);
    assign w_emit     = w_res.differ && (r_count < CNT_W'(krce_pkg::MAX_EVENTS));
    assign w_out_free = !r_out_v || o_ev.ready;
    // a new event bumps the held one to the output, so stall if that is full
    assign w_go       = w_scan && !(w_emit && r_pend_v && !w_out_free);
    assign w_push     = (w_go && w_emit && r_pend_v)
                      || (r_state == ST_FLUSH && r_pend_v && w_out_free);

    // the held event leaving at flush is the final one of the item
    always_comb begin
        w_out_next      = r_pend;
        w_out_next.last = (r_state == ST_FLUSH);
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_ev.valid      = r_out_v;
    assign o_ev.event_kind = r_out.event_kind;
    assign o_ev.event_pad  = r_out.event_pad;
    assign o_ev.note       = r_out.note;
    assign o_ev.value      = r_out.value;
    assign o_ev.value_y    = r_out.value_y;
    assign o_ev.value_z    = r_out.value_z;
    assign o_ev.last       = r_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_use_midi <= 1'b0;
            r_key      <= '0;
            r_fld      <= krce_pkg::EV_SUSTAIN;
            r_slot     <= '0;
            r_count    <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            for (int p = 0; p < PAD_COUNT; p++) begin
                r_key_down[p] <= '0;
                r_pst[p]      <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_use_midi <= i_cfg.use_midi_port;
            end

            if (w_push) begin
                r_out   <= w_out_next;
                r_out_v <= 1'b1;
            end else if (o_ev.ready) begin
                r_out_v <= 1'b0;
            end

            if (w_go && w_emit) begin
                r_pend   <= w_res.ev;
                r_pend_v <= 1'b1;
                r_count  <= r_count + 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && !r_use_midi && w_pad_ok) begin
                        r_rep.pad              <= i_in.pad;
                        r_rep.report_head      <= i_in.report_head;
                        r_rep.sustain_pedal    <= i_in.sustain_pedal;
                        r_rep.stomp_pedal      <= i_in.stomp_pedal;
                        r_rep.axis_x           <= i_in.axis_x;
                        r_rep.axis_y           <= i_in.axis_y;
                        r_rep.axis_z           <= i_in.axis_z;
                        r_rep.expression_pedal <= i_in.expression_pedal;
                        r_rep.accessories      <= i_in.accessories;
                        r_rep.low_hand         <= i_in.low_hand;
                        r_rep.high_hand_bits   <= i_in.high_hand_bits;
                        r_key   <= '0;
                        r_slot  <= SW'(1);
                        r_count <= '0;
                        r_state <= ST_KEYS;
                    end
                end
                ST_KEYS: begin
                    if (w_go) begin
                        if (w_res.differ) begin
                            r_key_down[w_pidx][r_key] <= w_step.key_now;
                        end
                        // held and new presses both use up a slot
                        if (w_step.key_now) begin
                            r_slot <= r_slot + 1'b1;
                        end
                        if (r_key == KW'(KEY_COUNT - 1)) begin
                            r_fld   <= krce_pkg::EV_SUSTAIN;
                            r_state <= ST_FIELDS;
                        end else begin
                            r_key <= r_key + 1'b1;
                        end
                    end
                end
                ST_FIELDS: begin
                    if (w_go) begin
                        r_pst[w_pidx] <= w_res.state;
                        if (r_fld == krce_pkg::EV_ACCEL) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_fld <= krce_pkg::t_kind'(r_fld + 4'd1);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `KRCE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(krce_pkg::MAX_EVENTS))
    `KRCE_IMPLY(a_idle_empty, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_v)
    `KRCE_IMPLY(a_busy_blocks, i_clk, i_rst_n, r_state != ST_IDLE, !i_in.ready)
    `KRCE_IMPLY(a_pend_count, i_clk, i_rst_n, r_pend_v, r_count != '0)

endmodule

// ----- tb/keyboard_report_change_events_tb.sv -----
// Self-checking bench for keyboard_report_change_events: drives pad reports,
// predicts the change events per pad and checks every event in order.
// Depends on krce_pkg, the krce channel interfaces and the top-level RTL.
`timescale 1ns / 1ps

module keyboard_report_change_events_tb;

    localparam int NUM_PADS     = 4;
    localparam int NUM_KEYS     = 25;
    localparam int NUM_SLOTS    = 5;
    localparam int SETTLE_TICKS = 60;    // time for a silent scan to finish, plus margin
    localparam int STALL_LIMIT  = 3000;  // cycles with no item moving anywhere
    localparam int LONG_HOLD    = 400;
    localparam int SHOW_MAX     = 30;

    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_EVERY_THIRD,
        RX_BURSTY
    } t_rx_mode;

    // Tracks per-pad stored state and the queue of events still owed by the DUT.
    class change_event_board;
        bit                   midi_port;
        logic [24:0]          keys_held[NUM_PADS];
        krce_pkg::t_pad_state fields_held[NUM_PADS];
        krce_pkg::t_event     pending_events[$];
        int                   mismatches;

        function new();
            midi_port  = 1'b0;
            mismatches = 0;
            foreach (keys_held[i]) begin
                keys_held[i]   = '0;
                fields_held[i] = '0;
            end
        endfunction

        function krce_pkg::t_event make_event(krce_pkg::t_kind kind, logic [1:0] p,
                                              logic [6:0] note, logic [7:0] v,
                                              logic [7:0] vy, logic [7:0] vz);
            krce_pkg::t_event ev;
            ev.event_kind = kind;
            ev.event_pad  = p;
            ev.note       = note;
            ev.value      = v;
            ev.value_y    = vy;
            ev.value_z    = vz;
            ev.last       = 1'b0;
            return ev;
        endfunction

        function void note_report(krce_pkg::t_report r);
            krce_pkg::t_event     found[$];
            krce_pkg::t_pad_state s;
            logic [1:0]  p;
            logic [23:0] tilt;
            logic [7:0]  vel;
            logic        now_down;
            int          slot;
            int          k;
            if (midi_port)
                return;
            p    = r.pad;
            s    = fields_held[p];
            slot = 1;
            for (k = 0; k < NUM_KEYS; k++) begin
                // key k lives at bit 7-k%8 of byte k/8, i.e. head bit 63-k
                now_down = r.report_head[63 - k];
                if (now_down != keys_held[p][k]) begin
                    if (now_down) begin
                        vel = '0;
                        if (slot <= NUM_SLOTS)
                            vel = 8'((r.report_head >> (56 - 8 * (slot + 2))) & 64'h7F);
                        slot++;
                        found.push_back(make_event(krce_pkg::EV_PRESS, p,
                                                   krce_pkg::BASE_NOTE + 7'(k), vel,
                                                   '0, '0));
                    end else begin
                        found.push_back(make_event(krce_pkg::EV_RELEASE, p,
                                                   krce_pkg::BASE_NOTE + 7'(k), '0,
                                                   '0, '0));
                    end
                    keys_held[p][k] = now_down;
                end else if (now_down) begin
                    slot++;   // held keys use up a slot too
                end
            end
            if (r.sustain_pedal != s.sustain) begin
                s.sustain = r.sustain_pedal;
                found.push_back(make_event(krce_pkg::EV_SUSTAIN, p, '0,
                                           {7'b0, r.sustain_pedal}, '0, '0));
            end
            if (r.stomp_pedal != s.stomp) begin
                s.stomp = r.stomp_pedal;
                found.push_back(make_event(krce_pkg::EV_STOMP, p, '0,
                                           {7'b0, r.stomp_pedal}, '0, '0));
            end
            if (r.axis_x != s.mod) begin
                s.mod = r.axis_x;
                found.push_back(make_event(krce_pkg::EV_MOD, p, '0, r.axis_x, '0, '0));
            end
            if (r.expression_pedal != s.expr) begin
                s.expr = r.expression_pedal;
                found.push_back(make_event(krce_pkg::EV_EXPRESSION, p, '0,
                                           r.expression_pedal, '0, '0));
            end
            if (r.accessories != s.acc) begin
                s.acc = r.accessories;
                found.push_back(make_event(krce_pkg::EV_ACCESSORIES, p, '0,
                                           r.accessories, '0, '0));
            end
            if (r.low_hand != s.low) begin
                s.low = r.low_hand;
                found.push_back(make_event(krce_pkg::EV_LOW_HAND, p, '0, r.low_hand,
                                           '0, '0));
            end
            if (r.high_hand_bits != s.high) begin
                s.high = r.high_hand_bits;
                found.push_back(make_event(krce_pkg::EV_HIGH_HAND, p, '0,
                                           {4'b0, r.high_hand_bits}, '0, '0));
            end
            tilt = {r.axis_x, r.axis_y, r.axis_z};
            if (tilt != s.tilt) begin
                s.tilt = tilt;
                found.push_back(make_event(krce_pkg::EV_ACCEL, p, '0, r.axis_x, r.axis_y,
                                           r.axis_z));
            end
            fields_held[p] = s;
            // overflow: state is updated but only the first events leave
            while (found.size() > krce_pkg::MAX_EVENTS)
                void'(found.pop_back());
            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                pending_events.push_back(found[i]);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= SHOW_MAX)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_event(krce_pkg::t_event got);
            krce_pkg::t_event want;
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event k%0d p%0d n%0d v%0h y%0h z%0h l%0d",
                    got.event_kind, got.event_pad, got.note, got.value, got.value_y,
                    got.value_z, got.last));
                return;
            end
            want = pending_events.pop_front();
            if (got.event_kind !== want.event_kind || got.event_pad !== want.event_pad ||
                got.note !== want.note || got.value !== want.value ||
                got.value_y !== want.value_y || got.value_z !== want.value_z ||
                got.last !== want.last)
                report_mismatch($sformatf(
                    "got k%0d p%0d n%0d v%0h y%0h z%0h l%0d, want k%0d p%0d n%0d v%0h y%0h z%0h l%0d",
                    got.event_kind, got.event_pad, got.note, got.value, got.value_y,
                    got.value_z, got.last, want.event_kind, want.event_pad, want.note,
                    want.value, want.value_y, want.value_z, want.last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    krce_report_if rep_if ();
    krce_event_if  ev_if ();
    krce_cfg_if    cfg_if ();

    keyboard_report_change_events u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rep_if),
        .o_ev    (ev_if),
        .i_cfg   (cfg_if)
    );

    change_event_board sb;
    krce_pkg::t_report last_sent[NUM_PADS];
    int                hold_cycles;
    int                idle_count;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: changes its stall pattern every so often; honors a long hold request.
    t_rx_mode rx_mode;
    int       rx_count;
    int       rx_stall;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            ev_if.ready = 1'b0;
            hold_cycles--;
        end else begin
            if (rx_count == 0) begin
                rx_mode  = t_rx_mode'($urandom_range(0, 3));
                rx_count = $urandom_range(20, 120);
            end
            rx_count--;
            case (rx_mode)
                RX_STEADY:      ev_if.ready = 1'b1;
                RX_RANDOM:      ev_if.ready = ($urandom_range(0, 9) > 2);
                RX_EVERY_THIRD: ev_if.ready = (rx_count % 3 == 0);
                default: begin
                    if (rx_stall > 0) begin
                        ev_if.ready = 1'b0;
                        rx_stall--;
                    end else if ($urandom_range(0, 7) == 0) begin
                        ev_if.ready = 1'b0;
                        rx_stall    = $urandom_range(1, 8);
                    end else begin
                        ev_if.ready = 1'b1;
                    end
                end
            endcase
        end
    end

    // Monitor: predicts on accepted reports, checks accepted events, guards for hangs.
    always @(posedge i_clk) begin
        krce_pkg::t_report rep;
        krce_pkg::t_event  got;
        bit                moved;
        if (!i_rst_n) begin
            idle_count = 0;
        end else begin
            moved = 1'b0;
            if (cfg_if.valid && cfg_if.ready) begin
                sb.midi_port = cfg_if.use_midi_port;
                moved = 1'b1;
            end
            if (rep_if.valid && rep_if.ready) begin
                rep.pad              = rep_if.pad;
                rep.report_head      = rep_if.report_head;
                rep.sustain_pedal    = rep_if.sustain_pedal;
                rep.stomp_pedal      = rep_if.stomp_pedal;
                rep.axis_x           = rep_if.axis_x;
                rep.axis_y           = rep_if.axis_y;
                rep.axis_z           = rep_if.axis_z;
                rep.expression_pedal = rep_if.expression_pedal;
                rep.accessories      = rep_if.accessories;
                rep.low_hand         = rep_if.low_hand;
                rep.high_hand_bits   = rep_if.high_hand_bits;
                sb.note_report(rep);
                moved = 1'b1;
            end
            if (ev_if.valid && ev_if.ready) begin
                got.event_kind = krce_pkg::t_kind'(ev_if.event_kind);
                got.event_pad  = ev_if.event_pad;
                got.note       = ev_if.note;
                got.value      = ev_if.value;
                got.value_y    = ev_if.value_y;
                got.value_z    = ev_if.value_z;
                got.last       = ev_if.last;
                sb.check_event(got);
                moved = 1'b1;
            end
            idle_count = moved ? 0 : idle_count + 1;
            if (idle_count >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_report(input krce_pkg::t_report r);
        @(negedge i_clk);
        rep_if.pad              = r.pad;
        rep_if.report_head      = r.report_head;
        rep_if.sustain_pedal    = r.sustain_pedal;
        rep_if.stomp_pedal      = r.stomp_pedal;
        rep_if.axis_x           = r.axis_x;
        rep_if.axis_y           = r.axis_y;
        rep_if.axis_z           = r.axis_z;
        rep_if.expression_pedal = r.expression_pedal;
        rep_if.accessories      = r.accessories;
        rep_if.low_hand         = r.low_hand;
        rep_if.high_hand_bits   = r.high_hand_bits;
        rep_if.valid            = 1'b1;
        do @(posedge i_clk); while (!rep_if.ready);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        rep_if.valid = 1'b0;
    endtask

    task automatic write_midi_port(input logic v);
        @(negedge i_clk);
        cfg_if.use_midi_port = v;
        cfg_if.valid         = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Wait for every owed event, then let any silent scan run out.
    task automatic settle();
        while (sb.pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    // Mostly small edits to the pad's previous report so keys stay held and
    // each field changes only now and then; some fully random, all-keys-flip and unchanged reports.
    function automatic krce_pkg::t_report next_report();
        krce_pkg::t_report r;
        int      p;
        int      pick;
        int      n;
        p    = $urandom_range(0, NUM_PADS - 1);
        pick = $urandom_range(0, 99);
        r    = last_sent[p];
        if (pick < 15) begin
            r.report_head      = {$urandom, $urandom};
            r.sustain_pedal    = 1'($urandom);
            r.stomp_pedal      = 1'($urandom);
            r.axis_x           = rand8();
            r.axis_y           = rand8();
            r.axis_z           = rand8();
            r.expression_pedal = rand8();
            r.accessories      = rand8();
            r.low_hand         = rand8();
            r.high_hand_bits   = 4'($urandom);
        end else if (pick < 23) begin
            r.report_head[63:39] = ~r.report_head[63:39];
            r.sustain_pedal      = ~r.sustain_pedal;
            r.stomp_pedal        = ~r.stomp_pedal;
            r.axis_x             = ~r.axis_x;
            r.axis_y             = rand8();
            r.expression_pedal   = ~r.expression_pedal;
            r.accessories        = ~r.accessories;
            r.low_hand           = ~r.low_hand;
            r.high_hand_bits     = ~r.high_hand_bits;
        end else if (pick < 93) begin
            n = $urandom_range(0, 4);
            repeat (n) r.report_head[63 - $urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
            if ($urandom_range(0, 5) == 0) r.sustain_pedal    = ~r.sustain_pedal;
            if ($urandom_range(0, 5) == 0) r.stomp_pedal      = ~r.stomp_pedal;
            if ($urandom_range(0, 5) == 0) r.axis_x           = rand8();
            if ($urandom_range(0, 5) == 0) r.axis_y           = rand8();
            if ($urandom_range(0, 5) == 0) r.axis_z           = rand8();
            if ($urandom_range(0, 5) == 0) r.expression_pedal = rand8();
            if ($urandom_range(0, 5) == 0) r.accessories      = rand8();
            if ($urandom_range(0, 5) == 0) r.low_hand         = rand8();
            if ($urandom_range(0, 5) == 0) r.high_hand_bits   = 4'($urandom);
        end
        // velocity bytes below the key bits are fresh on every report
        r.report_head[38:0] = 39'({$urandom, $urandom});
        r.pad        = 2'(p);
        last_sent[p] = r;
        return r;
    endfunction

    task automatic send_random(input int count);
        int sent;
        int burst;
        int gap;
        int i;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (i = 0; i < burst && sent < count; i++) begin
                send_report(next_report());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                release_input();
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        release_input();
    endtask

    initial begin
        krce_pkg::t_report d;
        sb          = new();
        hold_cycles = 0;
        rx_count    = 0;
        rx_stall    = 0;
        rx_mode     = RX_STEADY;
        idle_count  = 0;
        foreach (last_sent[i])
            last_sent[i] = '0;
        i_rst_n              = 1'b0;
        rep_if.valid         = 1'b0;
        rep_if.pad           = '0;
        rep_if.report_head   = '0;
        rep_if.sustain_pedal = 1'b0;
        rep_if.stomp_pedal   = 1'b0;
        rep_if.axis_x        = '0;
        rep_if.axis_y        = '0;
        rep_if.axis_z        = '0;
        rep_if.expression_pedal = '0;
        rep_if.accessories   = '0;
        rep_if.low_hand      = '0;
        rep_if.high_hand_bits = '0;
        ev_if.ready          = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.use_midi_port = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_midi_port(1'b0);

        // matches reset state: no events
        d = '0;
        send_report(d);
        // everything changes: 33 candidates, the accelerometer event is dropped
        d.report_head      = '1;
        d.sustain_pedal    = 1'b1;
        d.stomp_pedal      = 1'b1;
        d.axis_x           = 8'hFF;
        d.axis_y           = 8'hFF;
        d.axis_z           = 8'hFF;
        d.expression_pedal = 8'hFF;
        d.accessories      = 8'hFF;
        d.low_hand         = 8'hFF;
        d.high_hand_bits   = 4'hF;
        send_report(d);
        // same again: tilt was stored although its event was dropped
        send_report(d);
        // all released, all fields back to zero: overflow again
        d = '0;
        send_report(d);

        // pad 3: key 0 and key 24 (byte 3 top bit) pressed; velocity masked to 7 bits
        d = '0;
        d.pad                = 2'd3;
        d.report_head[63]    = 1'b1;
        d.report_head[39:32] = 8'hFF;
        d.report_head[31:24] = 8'h55;
        d.report_head[23:16] = 8'hAA;
        send_report(d);
        // held keys still advance the slot: key 12 takes slot 2
        d.report_head[63 - 12] = 1'b1;
        d.report_head[31:24]   = 8'h3C;
        send_report(d);
        d.report_head[63] = 1'b0;
        send_report(d);

        // pad 1: six new presses, the sixth gets velocity zero
        d = '0;
        d.pad               = 2'd1;
        d.report_head[62]   = 1'b1;
        d.report_head[60]   = 1'b1;
        d.report_head[58]   = 1'b1;
        d.report_head[56]   = 1'b1;
        d.report_head[54]   = 1'b1;
        d.report_head[52]   = 1'b1;
        d.report_head[38:0] = 39'h7F_8081_FF01;
        send_report(d);

        // pad 2: one field at a time
        d = '0;
        d.pad = 2'd2;
        d.sustain_pedal    = 1'b1;  send_report(d);
        d.stomp_pedal      = 1'b1;  send_report(d);
        d.axis_x           = 8'h80; send_report(d);
        d.axis_y           = 8'h01; send_report(d);
        d.axis_z           = 8'hFE; send_report(d);
        d.expression_pedal = 8'h7F; send_report(d);
        d.accessories      = 8'hA5; send_report(d);
        d.low_hand         = 8'h5A; send_report(d);
        d.high_hand_bits   = 4'hA;  send_report(d);
        d.high_hand_bits   = 4'h5;  send_report(d);
        release_input();
        settle();

        // keep the generator in step with what the directed part left behind
        foreach (last_sent[i])
            last_sent[i] = '0;
        last_sent[2] = d;
        last_sent[3].pad = 2'd3;
        last_sent[3].report_head[63:39] = 25'h1 | (25'h1 << 12);
        last_sent[1].report_head[63:39] = {1'b0, 11'b101_0101_0101, 13'b0};

        // long receiver hold while reports keep coming: the block backs up
        hold_cycles = LONG_HOLD;
        send_random(200);
        settle();

        write_midi_port(1'b1);
        send_random(25);
        settle();
        write_midi_port(1'b0);
        send_random(200);
        settle();

        write_midi_port(1'b1);
        send_random(20);
        settle();
        write_midi_port(1'b0);
        send_random(30);
        settle();

        if (sb.pending_events.size() != 0)
            sb.report_mismatch($sformatf("%0d events never arrived", sb.pending_events.size()));
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- keyboard_report_change_events.f -----
+incdir+rtl
rtl/krce_pkg.sv
rtl/krce_ifs.sv
rtl/krce_unit.sv
rtl/keyboard_report_change_events.sv
tb/keyboard_report_change_events_tb.sv
